[design/mqbld_pkg.sv]
// Package for the MIME quoted-printable / base64 line decoder.
// Holds sizes, character codes, controller and datapath types, and digit decoders.
// No dependencies.
package mqbld_pkg;

  localparam int PREFIX_LEN = 10;
  localparam int CNT_W = $clog2(PREFIX_LEN + 1);
  localparam int IDX_W = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;

  localparam logic [6:0] B64_BAD = 7'd64;
  localparam logic [4:0] HEX_BAD = 5'd16;

  localparam logic [7:0] CH_Q  = 8'h3F;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LQ = 8'h71;
  localparam logic [7:0] CH_LB = 8'h62;

  typedef enum logic [2:0] {
    LK_NONE,
    LK_Q,
    LK_QEQ,
    LK_EQ,
    LK_HEX
  } esc_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAR,
    ST_END_PREP,
    ST_REPLAY,
    ST_FIN_PEND,
    ST_FIN_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PASS,
    OP_STORE,
    OP_REPLAY_START,
    OP_END_REPLAY_START,
    OP_DISP_STORE,
    OP_REPLAY_CLOSE,
    OP_DISP_CUR,
    OP_FIN_PEND,
    OP_FIN_OUT
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic enable;
    logic prefix_open;
    logic cur_b64ok;
    logic store_room;
    logic replay_left;
    logic cur_end;
    logic op_done;
  } dp_status_t;

  function automatic logic [6:0] b64val(input logic [7:0] c);
    logic [6:0] v;
    v = B64_BAD;
    if (c inside {[8'h41:8'h5A]}) v = 7'(c - 8'h41);
    else if (c inside {[8'h61:8'h7A]}) v = 7'(c - 8'd71);
    else if (c inside {[8'h30:8'h39]}) v = 7'(c + 8'd4);
    else if (c == 8'h2B) v = 7'd62;
    else if (c == 8'h2F) v = 7'd63;
    return v;
  endfunction

  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BAD;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    return v;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SP, [8'h09:8'h0D]};
  endfunction

endpackage

[design/mqbld_ifs.sv]
// Valid/ready channel interfaces for the decoder's input and result streams.
// No dependencies.
interface mqbld_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_start;
  logic       string_end;
  logic       preset_qp;
  logic       preset_base64;

  modport source (output valid, data_byte, string_start, string_end, preset_qp, preset_base64,
                  input ready);
  modport sink (input valid, data_byte, string_start, string_end, preset_qp, preset_base64,
                output ready);
endinterface

interface mqbld_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;

  modport source (output valid, out_byte, byte_valid, string_done, input ready);
  modport sink (input valid, out_byte, byte_valid, string_done, output ready);
endinterface

[design/mqbld_ctrl.sv]
// Controller state machine: sequences prefix check, replay, dispatch and finish.
// Depends on mqbld_pkg.
module mqbld_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  mqbld_pkg::dp_status_t status,
  output mqbld_pkg::dp_cmd_t    cmd
);

  mqbld_pkg::ctrl_state_t state, state_next;
  logic end_phase, end_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mqbld_pkg::ST_IDLE;
      end_phase <= 1'b0;
    end else begin
      state     <= state_next;
      end_phase <= end_phase_next;
    end
  end

  always_comb begin
    state_next     = state;
    end_phase_next = end_phase;
    cmd.take       = 1'b0;
    cmd.op         = mqbld_pkg::OP_NONE;
    case (state)
      mqbld_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.item_valid) state_next = mqbld_pkg::ST_CHAR;
      end
      mqbld_pkg::ST_CHAR: begin
        if (!status.enable) begin
          cmd.op = mqbld_pkg::OP_PASS;
          if (status.op_done) state_next = mqbld_pkg::ST_IDLE;
        end else if (status.prefix_open) begin
          if (status.cur_b64ok && status.store_room) begin
            cmd.op     = mqbld_pkg::OP_STORE;
            state_next = status.cur_end ? mqbld_pkg::ST_END_PREP : mqbld_pkg::ST_IDLE;
          end else begin
            cmd.op         = mqbld_pkg::OP_REPLAY_START;
            end_phase_next = 1'b0;
            state_next     = mqbld_pkg::ST_REPLAY;
          end
        end else begin
          cmd.op = mqbld_pkg::OP_DISP_CUR;
          if (status.op_done)
            state_next = status.cur_end ? mqbld_pkg::ST_FIN_PEND : mqbld_pkg::ST_IDLE;
        end
      end
      mqbld_pkg::ST_END_PREP: begin
        cmd.op         = mqbld_pkg::OP_END_REPLAY_START;
        end_phase_next = 1'b1;
        state_next     = mqbld_pkg::ST_REPLAY;
      end
      mqbld_pkg::ST_REPLAY: begin
        if (status.replay_left) begin
          cmd.op = mqbld_pkg::OP_DISP_STORE;
        end else begin
          cmd.op     = mqbld_pkg::OP_REPLAY_CLOSE;
          state_next = end_phase ? mqbld_pkg::ST_FIN_PEND : mqbld_pkg::ST_CHAR;
        end
      end
      mqbld_pkg::ST_FIN_PEND: begin
        cmd.op = mqbld_pkg::OP_FIN_PEND;
        if (status.op_done) state_next = mqbld_pkg::ST_FIN_OUT;
      end
      mqbld_pkg::ST_FIN_OUT: begin
        cmd.op = mqbld_pkg::OP_FIN_OUT;
        if (status.op_done) state_next = mqbld_pkg::ST_IDLE;
      end
      default: state_next = mqbld_pkg::ST_IDLE;
    endcase
  end

endmodule

[design/mqbld_datapath.sv]
// Datapath: decoder state, prefix store, output register; one decode step per cycle unless the output stalls.
// Depends on mqbld_pkg and the channel interfaces in mqbld_ifs.
module mqbld_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  decode_enable,
  input  mqbld_pkg::dp_cmd_t     cmd,
  output mqbld_pkg::dp_status_t  status,
  mqbld_item_if.sink            item,
  mqbld_result_if.source        result
);

  logic [7:0] cur_byte;
  logic       cur_end;

  logic [7:0] prefix_store [mqbld_pkg::PREFIX_LEN];
  logic [mqbld_pkg::CNT_W-1:0] prefix_count, prefix_count_next;
  logic [mqbld_pkg::CNT_W-1:0] replay_idx, replay_idx_next;
  logic prefix_open, prefix_open_next;

  logic qp_mode, qp_mode_next;
  logic base64_mode, base64_mode_next;
  logic pad_seen, pad_seen_next;
  logic [5:0] group_digits [3];
  logic [5:0] group_digits_next [3];
  logic [1:0] group_count, group_count_next;
  logic group_on, group_on_next;
  logic pad_head, pad_head_next;
  logic pad_third, pad_third_next;
  logic [1:0] flush_phase, flush_phase_next;
  mqbld_pkg::esc_kind_t esc_kind, esc_kind_next;
  logic [7:0] esc_char, esc_char_next;
  logic [1:0] hdr_cnt, hdr_cnt_next;
  logic [7:0] hdr_sel, hdr_sel_next;
  logic [8:0] held_byte, held_byte_next;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_bvalid;
  logic       out_done;

  logic accept, out_free, commit, store_we;
  logic emit, emit_bvalid, emit_done;
  logic [7:0] emit_byte;
  logic [7:0] ch;
  logic pc_en, prod_en, char_fin, do_init, init_qp, init_b64;
  logic [7:0] pc_char, prod_b;
  logic [6:0] v;
  logic [4:0] hi, lo;
  logic [7:0] hexb;

  assign accept   = cmd.take && item.valid;
  assign out_free = !out_valid || result.ready;
  assign commit   = !(emit && !out_free);
  assign item.ready = cmd.take;

  assign ch = (cmd.op == mqbld_pkg::OP_DISP_STORE) ?
              prefix_store[replay_idx[mqbld_pkg::IDX_W-1:0]] : cur_byte;

  always_comb begin
    prefix_count_next = prefix_count;
    replay_idx_next   = replay_idx;
    prefix_open_next  = prefix_open;
    qp_mode_next      = qp_mode;
    base64_mode_next  = base64_mode;
    pad_seen_next     = pad_seen;
    group_digits_next = group_digits;
    group_count_next  = group_count;
    group_on_next     = group_on;
    pad_head_next     = pad_head;
    pad_third_next    = pad_third;
    flush_phase_next  = flush_phase;
    esc_kind_next     = esc_kind;
    esc_char_next     = esc_char;
    hdr_cnt_next      = hdr_cnt;
    hdr_sel_next      = hdr_sel;
    held_byte_next    = held_byte;
    emit        = 1'b0;
    emit_byte   = 8'h00;
    emit_bvalid = 1'b0;
    emit_done   = 1'b0;
    pc_en    = 1'b0;
    pc_char  = 8'h00;
    prod_en  = 1'b0;
    prod_b   = 8'h00;
    char_fin = 1'b1;
    do_init  = 1'b0;
    init_qp  = 1'b0;
    init_b64 = 1'b0;
    store_we = 1'b0;
    v    = mqbld_pkg::b64val(ch);
    hi   = mqbld_pkg::hexval(esc_char);
    lo   = mqbld_pkg::hexval(ch);
    hexb = 8'hFF;

    if (accept && item.string_start) begin
      do_init  = 1'b1;
      init_qp  = item.preset_qp;
      init_b64 = item.preset_base64;
    end

    case (cmd.op)
      mqbld_pkg::OP_PASS: begin
        emit        = 1'b1;
        emit_byte   = cur_byte;
        emit_bvalid = 1'b1;
        emit_done   = cur_end;
        do_init     = cur_end;
      end
      mqbld_pkg::OP_STORE: begin
        store_we          = 1'b1;
        prefix_count_next = prefix_count + 1'b1;
      end
      mqbld_pkg::OP_REPLAY_START: begin
        if (mqbld_pkg::b64val(cur_byte) == mqbld_pkg::B64_BAD) base64_mode_next = 1'b0;
        replay_idx_next = '0;
      end
      mqbld_pkg::OP_END_REPLAY_START: begin
        base64_mode_next = 1'b0;
        replay_idx_next  = '0;
      end
      mqbld_pkg::OP_REPLAY_CLOSE: begin
        prefix_open_next  = 1'b0;
        prefix_count_next = '0;
      end
      mqbld_pkg::OP_DISP_CUR, mqbld_pkg::OP_DISP_STORE: begin
        if (flush_phase == 2'd2) begin
          prod_en = 1'b1;
          prod_b  = {group_digits[1][3:0], group_digits[2][5:2]};
          if (ch == mqbld_pkg::CH_EQ) begin
            pad_seen_next    = 1'b1;
            flush_phase_next = 2'd0;
          end else begin
            flush_phase_next = 2'd3;
            char_fin         = 1'b0;
          end
        end else if (flush_phase == 2'd3) begin
          prod_en = 1'b1;
          prod_b  = (v == mqbld_pkg::B64_BAD) ? 8'hFF : {group_digits[2][1:0], v[5:0]};
          flush_phase_next = 2'd0;
        end else if (group_on) begin
          if (!mqbld_pkg::is_ws(ch)) begin
            if (group_count != 2'd3) begin
              if (ch == mqbld_pkg::CH_EQ) begin
                if (group_count < 2'd2) pad_head_next = 1'b1;
                else pad_third_next = 1'b1;
              end
              group_digits_next[group_count] = v[5:0];
              group_count_next = group_count + 2'd1;
            end else begin
              group_on_next    = 1'b0;
              group_count_next = 2'd0;
              if (pad_head) begin
                pad_seen_next = 1'b1;
              end else begin
                prod_en = 1'b1;
                prod_b  = {group_digits[0], group_digits[1][5:4]};
                if (pad_third) begin
                  pad_seen_next = 1'b1;
                end else begin
                  flush_phase_next = 2'd2;
                  char_fin         = 1'b0;
                end
              end
            end
          end
        end else if (hdr_cnt != 2'd0 || hdr_sel != 8'h00) begin
          if (ch != mqbld_pkg::CH_Q) begin
            if (hdr_cnt == 2'd2) hdr_sel_next = ch | mqbld_pkg::CH_SP;
          end else if (hdr_cnt == 2'd2) begin
            hdr_cnt_next = 2'd0;
            hdr_sel_next = 8'h00;
            if (hdr_sel == mqbld_pkg::CH_LQ) qp_mode_next = 1'b1;
            else if (hdr_sel == mqbld_pkg::CH_LB) base64_mode_next = 1'b1;
          end else begin
            hdr_cnt_next = hdr_cnt + 2'd1;
          end
        end else begin
          case (esc_kind)
            mqbld_pkg::LK_Q: begin
              if (ch == mqbld_pkg::CH_EQ) begin
                esc_kind_next = mqbld_pkg::LK_QEQ;
              end else begin
                // emit the held '?' first, then run this char again
                esc_kind_next = mqbld_pkg::LK_NONE;
                pc_en    = 1'b1;
                pc_char  = mqbld_pkg::CH_Q;
                char_fin = 1'b0;
              end
            end
            mqbld_pkg::LK_QEQ, mqbld_pkg::LK_EQ: begin
              esc_kind_next = mqbld_pkg::LK_NONE;
              if (esc_kind == mqbld_pkg::LK_QEQ && ch == mqbld_pkg::CH_SP) begin
                qp_mode_next     = 1'b0;
                base64_mode_next = 1'b0;
                pc_en   = 1'b1;
                pc_char = ch;
              end else if (ch == mqbld_pkg::CH_Q) begin
                hdr_cnt_next = 2'd1;
                hdr_sel_next = 8'h00;
              end else if (qp_mode) begin
                esc_kind_next = mqbld_pkg::LK_HEX;
                esc_char_next = ch;
              end else begin
                pc_en    = 1'b1;
                pc_char  = mqbld_pkg::CH_EQ;
                char_fin = 1'b0;
              end
            end
            mqbld_pkg::LK_HEX: begin
              esc_kind_next = mqbld_pkg::LK_NONE;
              if (lo != mqbld_pkg::HEX_BAD)
                hexb = {(hi == mqbld_pkg::HEX_BAD) ? 4'hF : hi[3:0], lo[3:0]};
              if (hexb != 8'hFF) begin
                prod_en = 1'b1;
                prod_b  = hexb;
              end
            end
            default: begin
              esc_kind_next = mqbld_pkg::LK_NONE;
              if (ch == mqbld_pkg::CH_Q) begin
                esc_kind_next = mqbld_pkg::LK_Q;
              end else if (ch == mqbld_pkg::CH_EQ) begin
                esc_kind_next = mqbld_pkg::LK_EQ;
              end else if (ch == mqbld_pkg::CH_NL) begin
                if (!base64_mode) begin
                  prod_en = 1'b1;
                  prod_b  = ch;
                end
                pad_seen_next    = 1'b0;
                qp_mode_next     = 1'b0;
                base64_mode_next = 1'b0;
              end else begin
                pc_en   = 1'b1;
                pc_char = ch;
              end
            end
          endcase
        end
      end
      mqbld_pkg::OP_FIN_PEND: begin
        // flush a dangling '?' or '=' as text
        if (!group_on && hdr_cnt == 2'd0 && hdr_sel == 8'h00) begin
          if (esc_kind == mqbld_pkg::LK_Q) begin
            pc_en   = 1'b1;
            pc_char = mqbld_pkg::CH_Q;
          end else if ((esc_kind == mqbld_pkg::LK_QEQ || esc_kind == mqbld_pkg::LK_EQ)
                       && !qp_mode) begin
            pc_en   = 1'b1;
            pc_char = mqbld_pkg::CH_EQ;
          end
        end
      end
      mqbld_pkg::OP_FIN_OUT: begin
        emit        = 1'b1;
        emit_bvalid = held_byte[8];
        emit_done   = 1'b1;
        if (held_byte[8])
          emit_byte = (!base64_mode && held_byte[7:0] == mqbld_pkg::CH_EQ) ?
                      mqbld_pkg::CH_NL : held_byte[7:0];
        do_init = 1'b1;
      end
      default: ;
    endcase

    // advance to the next held byte once this one is fully decoded
    if (cmd.op == mqbld_pkg::OP_DISP_STORE && char_fin) replay_idx_next = replay_idx + 1'b1;

    if (pc_en) begin
      if (base64_mode_next && !pad_seen_next) begin
        group_on_next    = 1'b1;
        group_count_next = 2'd0;
        pad_head_next    = 1'b0;
        pad_third_next   = 1'b0;
        if (!mqbld_pkg::is_ws(pc_char)) begin
          if (pc_char == mqbld_pkg::CH_EQ) pad_head_next = 1'b1;
          group_digits_next[0] = 6'(mqbld_pkg::b64val(pc_char) & 7'h3F);
          group_count_next     = 2'd1;
        end
      end else begin
        prod_en = 1'b1;
        prod_b  = pc_char;
      end
    end

    if (prod_en) begin
      emit           = held_byte[8];
      emit_byte      = held_byte[7:0];
      emit_bvalid    = 1'b1;
      emit_done      = 1'b0;
      held_byte_next = {1'b1, prod_b};
    end

    if (do_init) begin
      prefix_open_next  = 1'b1;
      prefix_count_next = '0;
      qp_mode_next      = init_qp;
      base64_mode_next  = init_b64;
      pad_seen_next     = 1'b0;
      group_count_next  = 2'd0;
      group_on_next     = 1'b0;
      pad_head_next     = 1'b0;
      pad_third_next    = 1'b0;
      flush_phase_next  = 2'd0;
      esc_kind_next     = mqbld_pkg::LK_NONE;
      hdr_cnt_next      = 2'd0;
      hdr_sel_next      = 8'h00;
      held_byte_next    = 9'h000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_count <= '0;
      replay_idx   <= '0;
      prefix_open  <= 1'b1;
      qp_mode      <= 1'b0;
      base64_mode  <= 1'b0;
      pad_seen     <= 1'b0;
      group_count  <= 2'd0;
      group_on     <= 1'b0;
      pad_head     <= 1'b0;
      pad_third    <= 1'b0;
      flush_phase  <= 2'd0;
      esc_kind     <= mqbld_pkg::LK_NONE;
      hdr_cnt      <= 2'd0;
      hdr_sel      <= 8'h00;
      held_byte    <= 9'h000;
    end else if (commit) begin
      prefix_count <= prefix_count_next;
      replay_idx   <= replay_idx_next;
      prefix_open  <= prefix_open_next;
      qp_mode      <= qp_mode_next;
      base64_mode  <= base64_mode_next;
      pad_seen     <= pad_seen_next;
      group_count  <= group_count_next;
      group_on     <= group_on_next;
      pad_head     <= pad_head_next;
      pad_third    <= pad_third_next;
      flush_phase  <= flush_phase_next;
      esc_kind     <= esc_kind_next;
      hdr_cnt      <= hdr_cnt_next;
      hdr_sel      <= hdr_sel_next;
      held_byte    <= held_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      group_digits <= group_digits_next;
      esc_char     <= esc_char_next;
    end
    if (accept) begin
      cur_byte <= item.data_byte;
      cur_end  <= item.string_end;
    end
    if (store_we) prefix_store[prefix_count[mqbld_pkg::IDX_W-1:0]] <= cur_byte;
  end

  // output register: load on a committed emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && commit) begin
      out_byte   <= emit_byte;
      out_bvalid <= emit_bvalid;
      out_done   <= emit_done;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.byte_valid  = out_bvalid;
  assign result.string_done = out_done;

  assign status.item_valid  = item.valid;
  assign status.enable      = decode_enable;
  assign status.prefix_open = prefix_open;
  assign status.cur_b64ok   = mqbld_pkg::b64val(cur_byte) != mqbld_pkg::B64_BAD;
  assign status.store_room  = prefix_count < mqbld_pkg::CNT_W'(mqbld_pkg::PREFIX_LEN - 1);
  assign status.replay_left = replay_idx < prefix_count;
  assign status.cur_end     = cur_end;
  assign status.op_done     = char_fin && commit;

endmodule

[design/mime_qp_base64_line_decoder_top.sv]
// A byte is taken in the idle state and decoded in the state after it; a finished base64
// group adds flush steps, a prefix replay adds a replay start, a dispatch per held byte
// and a replay close, and a string end adds the finish-pending and finish-output steps.
// Results leave through the output register; a stalled output holds the decode step.
// Reset (rst, synchronous): decoding enabled, all modes and pending state cleared.
// Depends on mqbld_pkg, mqbld_ifs, mqbld_ctrl and mqbld_datapath.
module mime_qp_base64_line_decoder_top (
  input  logic        clk,
  input  logic        rst,
  mqbld_item_if.sink  item,
  mqbld_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic decode_enable;
  mqbld_pkg::dp_cmd_t    cmd;
  mqbld_pkg::dp_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, decode_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      decode_enable <= pwdata[0];
    end
  end

  mqbld_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mqbld_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .decode_enable (decode_enable),
    .cmd           (cmd),
    .status        (status),
    .item          (item),
    .result        (result)
  );

endmodule
